[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ILS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked implication, next cycle, disabled while reset is asserted.
`define ILS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ils_pkg.sv]
`timescale 1ns / 1ps

package ils_pkg;

    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int CNT_OUT_W = 5;
    localparam int DEPTH_DEF = 16;

    localparam int IN_FIELDS_W  = OP_W + POS_W + DATA_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = DATA_W + STATUS_W + CNT_OUT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_APPEND = 3'd1,
        OP_REMOVE = 3'd2,
        OP_READ   = 3'd3,
        OP_WRITE  = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic load;
        logic take_prev;
        logic take_next;
        logic rd_sel;
    } t_cell_ctl;

endpackage

[hdl/indexed_list_store_top.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Indexed list store: ordered list of up to DEPTH signed 32-bit values.
// Input channel (s_axis): one operation per item, tdata = {value, position, op}.
//   op: insert front, append back, remove at index, read, write.
// Output channel (m_axis): one result per item, tdata = {count_now, status,
//   read_value}; status is ok, index out of range or list full.
// Storage is a row of DEPTH cells; insert shifts all occupied cells and remove
// those from the index on, each by one place from its neighbor, in the same cycle.
// Latency: result is valid the cycle after the item is accepted.
// Throughput: one item per cycle while the receiver takes results.
// A single output register separates the channels; the input is ready when
// that register is empty or being taken in the same cycle. When the receiver
// stalls, the result holds and no new item is taken.
// Reset (synchronous, active low) empties the list and drops any pending
// result; cell contents are not cleared and are never read before written.

module indexed_list_store_top #(
    parameter int DEPTH = ils_pkg::DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [2:0] op, [10:3] position, [42:11] value, [47:43] zero
    input  logic [ils_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [31:0] read_value, [33:32] status, [38:34] count_now, [39] zero
    output logic [ils_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > ils_pkg::POS_W) ? CW : ils_pkg::POS_W;
    localparam int DW   = ils_pkg::DATA_W;

    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic           r_m_valid;
    logic [ils_pkg::OUT_TDATA_W-1:0] r_m_data;
    logic [ils_pkg::OUT_TDATA_W-1:0] n_m_data;

    logic                       s_fire;
    ils_pkg::t_op               in_op;
    logic [ils_pkg::POS_W-1:0]  in_pos;
    logic [DW-1:0]              in_value;
    logic [CMPW-1:0]            pos_x;
    logic [CMPW-1:0]            cnt_x;
    logic                       is_full;
    logic                       pos_ok;
    logic                       do_insert;
    logic                       do_append;
    logic                       do_remove;
    logic                       do_write;
    logic                       do_read;
    ils_pkg::t_status           status;
    logic [DW-1:0]              rd_value;

    ils_pkg::t_cell_ctl         ctl   [DEPTH];
    logic [DW-1:0]              value [DEPTH];
    logic [DW-1:0]              rd    [DEPTH];

    assign in_op    = ils_pkg::t_op'(i_s_axis_tdata[ils_pkg::OP_W-1:0]);
    assign in_pos   = i_s_axis_tdata[ils_pkg::OP_W +: ils_pkg::POS_W];
    assign in_value = i_s_axis_tdata[ils_pkg::OP_W + ils_pkg::POS_W +: DW];

    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;

    assign pos_x   = CMPW'(in_pos);
    assign cnt_x   = CMPW'(r_count);
    assign is_full = (r_count == CW'(DEPTH));
    assign pos_ok  = (pos_x < cnt_x);

    always_comb begin
        do_insert = 1'b0;
        do_append = 1'b0;
        do_remove = 1'b0;
        do_write  = 1'b0;
        do_read   = 1'b0;
        status    = ils_pkg::ST_OK;
        n_count   = r_count;
        unique case (in_op)
            ils_pkg::OP_INSERT: begin
                if (is_full) begin
                    status = ils_pkg::ST_FULL;
                end else begin
                    do_insert = s_fire;
                    n_count   = r_count + CW'(1);
                end
            end
            ils_pkg::OP_APPEND: begin
                if (is_full) begin
                    status = ils_pkg::ST_FULL;
                end else begin
                    do_append = s_fire;
                    n_count   = r_count + CW'(1);
                end
            end
            ils_pkg::OP_REMOVE: begin
                if (pos_ok) begin
                    do_remove = s_fire;
                    n_count   = r_count - CW'(1);
                end
            end
            ils_pkg::OP_READ: begin
                if (pos_ok) begin
                    do_read = 1'b1;
                end else begin
                    status = ils_pkg::ST_RANGE;
                end
            end
            ils_pkg::OP_WRITE: begin
                if (pos_ok) begin
                    do_write = s_fire;
                end else begin
                    status = ils_pkg::ST_RANGE;
                end
            end
            default: begin
                status = ils_pkg::ST_OK;
            end
        endcase
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam logic [CMPW-1:0] IDX = CMPW'(i);

        always_comb begin
            ctl[i].load      = (do_insert && (i == 0)) ||
                               (do_append && (IDX == cnt_x)) ||
                               (do_write && (IDX == pos_x));
            ctl[i].take_prev = do_insert && (i > 0) && (IDX <= cnt_x);
            ctl[i].take_next = do_remove && (IDX >= pos_x) &&
                               ((IDX + CMPW'(1)) < cnt_x);
            ctl[i].rd_sel    = do_read && (IDX == pos_x);
        end

        ils_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl[i]),
            .i_load_value (in_value),
            .i_prev       ((i == 0) ? value[i] : value[(i == 0) ? 0 : i - 1]),
            .i_next       ((i == DEPTH - 1) ? value[i]
                                            : value[(i == DEPTH - 1) ? i : i + 1]),
            .o_value      (value[i]),
            .o_rd         (rd[i])
        );
    end

    always_comb begin
        rd_value = '0;
        for (int k = 0; k < DEPTH; k++) begin
            rd_value = rd_value | rd[k];
        end
    end

    always_comb begin
        n_m_data = '0;
        n_m_data[DW-1:0] = rd_value;
        n_m_data[DW +: ils_pkg::STATUS_W] = status;
        n_m_data[DW + ils_pkg::STATUS_W +: ils_pkg::CNT_OUT_W] =
            ils_pkg::CNT_OUT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (s_fire) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_m_data <= n_m_data;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    `ILS_ASSERT(a_count_bound, r_count <= CW'(DEPTH), "count exceeds depth")
    `ILS_ASSERT_NEXT(a_full_holds, s_fire && is_full &&
        (in_op == ils_pkg::OP_INSERT || in_op == ils_pkg::OP_APPEND),
        r_count == $past(r_count), "count changed on refused insert")
    `ILS_ASSERT(a_count_out, !r_m_valid ||
        (r_m_data[DW + ils_pkg::STATUS_W +: ils_pkg::CNT_OUT_W] ==
         ils_pkg::CNT_OUT_W'(r_count)), "pending count differs from list count")
    `ILS_ASSERT_NEXT(a_idle_count, !s_fire, r_count == $past(r_count),
        "count changed without an item")

endmodule

[hdl/ils_cell.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ils_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ils_pkg::t_cell_ctl           i_ctl,
    input  logic [ils_pkg::DATA_W-1:0]   i_load_value,
    input  logic [ils_pkg::DATA_W-1:0]   i_prev,
    input  logic [ils_pkg::DATA_W-1:0]   i_next,
    output logic [ils_pkg::DATA_W-1:0]   o_value,
    output logic [ils_pkg::DATA_W-1:0]   o_rd
);

    logic [ils_pkg::DATA_W-1:0] r_value;
    logic [ils_pkg::DATA_W-1:0] n_value;

    always_comb begin
        priority if (i_ctl.load) begin
            n_value = i_load_value;
        end else if (i_ctl.take_prev) begin
            n_value = i_prev;
        end else if (i_ctl.take_next) begin
            n_value = i_next;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_rd    = i_ctl.rd_sel ? r_value : '0;

    `ILS_ASSERT(a_one_source, $onehot0({i_ctl.load, i_ctl.take_prev, i_ctl.take_next}),
        "cell given more than one source")
    `ILS_ASSERT(a_read_no_update, !(i_ctl.rd_sel && (i_ctl.load || i_ctl.take_prev ||
        i_ctl.take_next)), "cell read and updated by one item")

endmodule

[tb/indexed_list_store_top_tb.sv]
`timescale 1ns / 1ps

module indexed_list_store_top_tb;

    localparam int          LIST_DEPTH = ils_pkg::DEPTH_DEF;
    localparam logic [2:0]  OP_RSVD_A  = 3'd5;
    localparam logic [2:0]  OP_RSVD_B  = 3'd6;
    localparam logic [2:0]  OP_RSVD_C  = 3'd7;
    localparam int          RAND_ITEMS = 1325;

    typedef struct packed {
        logic [31:0]      read_value;
        ils_pkg::t_status status;
        logic [4:0]       count_now;
    } t_list_result;

    typedef struct packed {
        logic [2:0]   op;
        logic [7:0]   pos;
        logic [31:0]  val;
        logic [7:0]   reps;
        logic         typed;
        t_list_result want;
    } t_list_op_row;

    localparam t_list_result NO_CHECK = '{32'h0, ils_pkg::ST_OK, 5'd0};

    localparam int N_ROWS = 25;
    localparam t_list_op_row DIRECTED_ROWS[N_ROWS] = '{
        '{ils_pkg::OP_READ,   8'd0,   32'h0,  8'd1, 1'b1, '{32'h0, ils_pkg::ST_RANGE, 5'd0}},
        '{ils_pkg::OP_WRITE,  8'd0,   32'h1234_5678, 8'd1, 1'b1,
          '{32'h0, ils_pkg::ST_RANGE, 5'd0}},
        '{ils_pkg::OP_REMOVE, 8'd0,   32'h0,  8'd1, 1'b1, '{32'h0, ils_pkg::ST_OK, 5'd0}},
        '{ils_pkg::OP_INSERT, 8'd0,   32'h7FFF_FFFF, 8'd1, 1'b1,
          '{32'h0, ils_pkg::ST_OK, 5'd1}},
        '{ils_pkg::OP_INSERT, 8'd255, 32'h8000_0000, 8'd1, 1'b1,
          '{32'h0, ils_pkg::ST_OK, 5'd2}},
        '{ils_pkg::OP_APPEND, 8'd0,   32'hFFFF_FFFF, 8'd1, 1'b0, NO_CHECK},
        '{ils_pkg::OP_APPEND, 8'd0,   32'h0,         8'd1, 1'b0, NO_CHECK},
        '{ils_pkg::OP_READ,   8'd0,   32'h0,         8'd1, 1'b0, NO_CHECK},
        '{ils_pkg::OP_READ,   8'd3,   32'h0,         8'd1, 1'b0, NO_CHECK},
        '{ils_pkg::OP_WRITE,  8'd1,   32'h5555_5555, 8'd1, 1'b0, NO_CHECK},
        '{ils_pkg::OP_READ,   8'd1,   32'h0,         8'd1, 1'b0, NO_CHECK},
        '{ils_pkg::OP_REMOVE, 8'd1,   32'h0,         8'd1, 1'b0, NO_CHECK},
        '{ils_pkg::OP_REMOVE, 8'd255, 32'h0,         8'd1, 1'b0, NO_CHECK},
        '{ils_pkg::OP_READ,   8'd255, 32'h0,  8'd1, 1'b1, '{32'h0, ils_pkg::ST_RANGE, 5'd3}},
        '{OP_RSVD_A,          8'd0,   32'hFFFF_FFFF, 8'd1, 1'b0, NO_CHECK},
        '{OP_RSVD_B,          8'd1,   32'h0,         8'd1, 1'b0, NO_CHECK},
        '{OP_RSVD_C,          8'd255, 32'hAAAA_AAAA, 8'd1, 1'b0, NO_CHECK},
        '{ils_pkg::OP_APPEND, 8'd0,   32'hAAAA_0000, 8'd13, 1'b0, NO_CHECK},
        '{ils_pkg::OP_INSERT, 8'd0,   32'h0BAD_0001, 8'd1, 1'b1,
          '{32'h0, ils_pkg::ST_FULL, 5'd16}},
        '{ils_pkg::OP_APPEND, 8'd0,   32'h0BAD_0002, 8'd1, 1'b1,
          '{32'h0, ils_pkg::ST_FULL, 5'd16}},
        '{ils_pkg::OP_READ,   8'd15,  32'h0,         8'd1, 1'b0, NO_CHECK},
        '{ils_pkg::OP_READ,   8'd16,  32'h0,  8'd1, 1'b1, '{32'h0, ils_pkg::ST_RANGE, 5'd16}},
        '{ils_pkg::OP_WRITE,  8'd15,  32'hA5A5_A5A5, 8'd1, 1'b0, NO_CHECK},
        '{ils_pkg::OP_REMOVE, 8'd15,  32'h0,         8'd1, 1'b0, NO_CHECK},
        '{ils_pkg::OP_REMOVE, 8'd0,   32'h0,         8'd1, 1'b0, NO_CHECK}
    };

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    // [2:0] op, [10:3] position, [42:11] value, [47:43] zero
    logic [ils_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    // [31:0] read_value, [33:32] status, [38:34] count_now, [39] zero
    logic [ils_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;

    logic [31:0]  list_cells[LIST_DEPTH];
    int           list_len = 0;
    t_list_result pending_results[$];
    int           mismatch_count = 0;
    int           items_sent = 0;
    int           results_seen = 0;
    int           op_hits[8];
    int           full_hits = 0;
    int           range_hits = 0;
    bit           quiet_stretch = 1'b0;

    indexed_list_store_top #(.DEPTH(LIST_DEPTH)) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic t_list_result apply_list_op(logic [2:0] op, logic [7:0] pos,
                                                   logic [31:0] val);
        t_list_result res;
        int k;
        res = '{32'h0, ils_pkg::ST_OK, 5'd0};
        if (op == ils_pkg::OP_INSERT) begin
            if (list_len >= LIST_DEPTH) begin
                res.status = ils_pkg::ST_FULL;
            end else begin
                for (k = list_len; k > 0; k--) list_cells[k] = list_cells[k-1];
                list_cells[0] = val;
                list_len++;
            end
        end else if (op == ils_pkg::OP_APPEND) begin
            if (list_len >= LIST_DEPTH) begin
                res.status = ils_pkg::ST_FULL;
            end else begin
                list_cells[list_len] = val;
                list_len++;
            end
        end else if (op == ils_pkg::OP_REMOVE) begin
            if (pos < list_len) begin
                for (k = pos; k + 1 < list_len; k++) list_cells[k] = list_cells[k+1];
                list_len--;
            end
        end else if (op == ils_pkg::OP_READ) begin
            if (pos < list_len) res.read_value = list_cells[pos];
            else res.status = ils_pkg::ST_RANGE;
        end else if (op == ils_pkg::OP_WRITE) begin
            if (pos < list_len) list_cells[pos] = val;
            else res.status = ils_pkg::ST_RANGE;
        end
        res.count_now = list_len[4:0];
        return res;
    endfunction

    task automatic send_item(logic [2:0] op, logic [7:0] pos, logic [31:0] val,
                             bit typed, t_list_result want);
        t_list_result res;
        begin
            while (!quiet_stretch && $urandom_range(0, 99) < 19) begin
                i_s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tdata  <= {5'b0, val, pos, op};
            @(posedge i_clk);
            while (!o_s_axis_tready) @(posedge i_clk);
            res = apply_list_op(op, pos, val);
            pending_results.push_back(typed ? want : res);
            op_hits[op]++;
            if (res.status == ils_pkg::ST_FULL) full_hits++;
            if (res.status == ils_pkg::ST_RANGE) range_hits++;
            items_sent++;
        end
    endtask

    task automatic wait_drained();
        int spins;
        begin
            spins = 0;
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while (pending_results.size() != 0 && spins < 20000) begin
                @(posedge i_clk);
                spins++;
            end
            if (pending_results.size() != 0) begin
                $error("results still outstanding: %0d", pending_results.size());
                mismatch_count++;
            end
        end
    endtask

    // result side: check, then pick next tready
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result item %h", o_m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tdata[31:0] !== want.read_value) begin
                    $error("read_value: expected %h, got %h",
                           want.read_value, o_m_axis_tdata[31:0]);
                    mismatch_count++;
                end
                if (o_m_axis_tdata[33:32] !== want.status) begin
                    $error("status: expected %0d, got %0d",
                           want.status, o_m_axis_tdata[33:32]);
                    mismatch_count++;
                end
                if (o_m_axis_tdata[38:34] !== want.count_now) begin
                    $error("count_now: expected %0d, got %0d",
                           want.count_now, o_m_axis_tdata[38:34]);
                    mismatch_count++;
                end
            end
        end
        i_m_axis_tready <= quiet_stretch || ($urandom_range(0, 99) >= 19);
    end

    initial begin
        t_list_op_row row;
        logic [2:0]   op;
        logic [7:0]   pos;
        int           pick;
        bit           growing;
        int           n;
        int           r;

        foreach (op_hits[k]) op_hits[k] = 0;
        foreach (list_cells[k]) list_cells[k] = '0;
        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < N_ROWS; n++) begin
            row = DIRECTED_ROWS[n];
            for (r = 0; r < row.reps; r++)
                send_item(row.op, row.pos, row.val + r, row.typed, row.want);
        end

        growing = 1'b1;
        for (n = 0; n < RAND_ITEMS; n++) begin
            quiet_stretch = (n >= 400 && n < 650);
            if (n == 700) wait_drained();
            if (list_len >= LIST_DEPTH) growing = 1'b0;
            else if (list_len == 0) growing = 1'b1;
            else if ($urandom_range(0, 99) < 3) growing = !growing;

            pick = $urandom_range(0, 99);
            if (pick < 5) op = 3'($urandom_range(OP_RSVD_A, OP_RSVD_C));
            else if (pick < 20) op = ils_pkg::OP_READ;
            else if (pick < 30) op = ils_pkg::OP_WRITE;
            else if (growing)
                op = (pick < 38) ? ils_pkg::OP_REMOVE
                   : (pick < 69 ? ils_pkg::OP_INSERT : ils_pkg::OP_APPEND);
            else
                op = (pick < 82) ? ils_pkg::OP_REMOVE
                   : (pick < 91 ? ils_pkg::OP_INSERT : ils_pkg::OP_APPEND);

            pick = $urandom_range(0, 99);
            if (pick < 75) pos = 8'($urandom_range(0, (list_len == 0) ? 0 : list_len - 1));
            else if (pick < 90) pos = 8'(list_len + $urandom_range(0, 2));
            else pos = 8'($urandom_range(0, 255));

            send_item(op, pos, $urandom, 1'b0, NO_CHECK);
        end
        quiet_stretch = 1'b0;

        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Ran %0d items, %0d results: insert %0d, append %0d, remove %0d,",
                 items_sent, results_seen, op_hits[ils_pkg::OP_INSERT],
                 op_hits[ils_pkg::OP_APPEND], op_hits[ils_pkg::OP_REMOVE]);
        $display("read %0d, write %0d, spare ops %0d; full refusals %0d, bad index %0d",
                 op_hits[ils_pkg::OP_READ], op_hits[ils_pkg::OP_WRITE],
                 op_hits[OP_RSVD_A] + op_hits[OP_RSVD_B] + op_hits[OP_RSVD_C],
                 full_hits, range_hits);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[indexed_list_store_top.f]
+incdir+hdl
hdl/ils_pkg.sv
hdl/ils_cell.sv
hdl/indexed_list_store_top.sv
tb/indexed_list_store_top_tb.sv
